// File: sv/lz77_token_stream_decoder_core_defines.svh
// Assertion macros for the LZ77 token stream decoder.
// Used by the top level only; needs a clk_i and an active-low rst_ni in scope.
`ifndef LZ77_TOKEN_STREAM_DECODER_CORE_DEFINES_SVH
`define LZ77_TOKEN_STREAM_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is applied.
`define LTD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is applied.
`define LTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ltd_pkg.sv
// Shared types and constants for the LZ77 token stream decoder.
// No dependencies.
package ltd_pkg;

  localparam int unsigned WinAw  = 16;
  localparam int unsigned ResDepth = 8;
  localparam int unsigned ResCntW  = 4;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_CAPACITY  = 3'd1;
  localparam logic [2:0] ERR_TRUNC     = 3'd2;
  localparam logic [2:0] ERR_ZERO_OFF  = 3'd3;
  localparam logic [2:0] ERR_BEFORE    = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd5;
  localparam logic [2:0] ERR_BUSY      = 3'd6;

  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_EXPECTED = 2'd1;

  localparam logic [3:0] NIB_EXT  = 4'hF;
  localparam logic [7:0] BYTE_EXT = 8'hFF;

  typedef enum logic [2:0] {
    PH_TOKEN, PH_LIT_EXT, PH_LITERALS, PH_OFF_LO, PH_OFF_HI, PH_MATCH_EXT, PH_COPY
  } phase_e;

  typedef struct packed {
    logic       is_pull;
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [31:0] total;
    logic [2:0]  code;
  } result_t;

endpackage

// File: sv/ltd_in_fifo.sv
// Front part: accepts stream items, classifies them into pull/feed, and queues them.
// Depends on ltd_pkg.
module ltd_in_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          opcode_i,
  input  logic [7:0]    data_i,
  input  logic          last_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ltd_pkg::item_t out_item_o
);

  ltd_pkg::item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Classify on entry: drop the byte field meaning for pulls.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q].is_pull <= opcode_i;
      mem_q[wr_ptr_q].data    <= data_i;
      mem_q[wr_ptr_q].last    <= last_i;
    end
  end

endmodule

// File: sv/ltd_res_queue.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while the receiver is ready.
// Depends on ltd_pkg.
module ltd_res_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push0_i,
  input  ltd_pkg::result_t res0_i,
  input  logic             push1_i,
  input  ltd_pkg::result_t res1_i,
  output logic [ltd_pkg::ResCntW-1:0] level_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ltd_pkg::result_t out_res_o
);

  localparam int unsigned Aw = ltd_pkg::ResCntW - 1;

  ltd_pkg::result_t mem_q [ltd_pkg::ResDepth];
  logic [Aw-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [ltd_pkg::ResCntW-1:0] cnt_q, cnt_d;
  logic pop;

  assign level_o     = cnt_q;
  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + Aw'(push0_i) + Aw'(push1_i);
    rd_ptr_d = rd_ptr_q + Aw'(pop);
    cnt_d    = cnt_q + ltd_pkg::ResCntW'(push0_i) + ltd_pkg::ResCntW'(push1_i)
             - ltd_pkg::ResCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Second result always lands right after the first.
  always_ff @(posedge clk_i) begin
    if (push0_i) mem_q[wr_ptr_q] <= res0_i;
    if (push1_i) mem_q[wr_ptr_q + Aw'(1)] <= res1_i;
  end

endmodule

// File: sv/ltd_engine.sv
// Back part: parses tokens, runs the history window, forms results in two stages.
// Depends on ltd_pkg.
module ltd_engine #(
  parameter int unsigned MinMatch = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ltd_pkg::item_t   item_i,
  input  logic [31:0]      capacity_i,
  input  logic [31:0]      expected_i,
  input  logic [ltd_pkg::ResCntW-1:0] level_i,
  output logic             push0_o,
  output ltd_pkg::result_t res0_o,
  output logic             push1_o,
  output ltd_pkg::result_t res1_o
);

  localparam int unsigned Aw = ltd_pkg::WinAw;

  typedef struct packed {
    logic          has_byte;
    logic          from_mem;
    logic          fwd;
    logic [7:0]    lit;
    logic [Aw-1:0] wr_addr;
    logic          done;
    logic [31:0]   total;
    logic          err;
    logic [2:0]    code;
  } s2_t;

  logic [7:0] win_q [2**Aw];
  logic [7:0] rdata_q, last_byte_q, cur_byte;

  ltd_pkg::phase_e ph_q, ph_d;
  logic [31:0] lit_q, lit_d, copy_q, copy_d, prod_q, prod_d;
  logic [3:0]  base_q, base_d;
  logic [15:0] off_q, off_d;
  logic        end_q, end_d, errl_q, errl_d;
  logic [2:0]  code_q, code_d;

  logic        s2v_q;
  s2_t         s2_q, s2_d;
  logic        fire, rd_en;
  logic [Aw-1:0] rd_addr;
  logic [32:0] ext_sum, cap_sum;
  logic [31:0] len_chk;
  logic [15:0] off_full;
  logic [4:0]  res_need;

  assign res_need   = {1'b0, level_i} + (s2v_q ? 5'd2 : 5'd0);
  assign in_ready_o = (res_need <= 5'(ltd_pkg::ResDepth - 2));
  assign fire       = in_valid_i && in_ready_o;
  assign rd_addr    = Aw'(prod_q - {16'd0, off_q});
  assign off_full   = {item_i.data, off_q[7:0]};

  always_comb begin
    ph_d = ph_q; lit_d = lit_q; copy_d = copy_q; prod_d = prod_q;
    base_d = base_q; off_d = off_q; end_d = end_q; errl_d = errl_q; code_d = code_q;
    s2_d = '0;
    rd_en = 1'b0;
    ext_sum = 33'd0;
    len_chk = 32'd0;
    cap_sum = 33'd0;
    s2_d.wr_addr = Aw'(prod_q);
    s2_d.lit = item_i.data;
    if (fire) begin
      if (errl_q) begin
        s2_d.err = 1'b1; s2_d.code = code_q;
      end else if (expected_i > capacity_i) begin
        s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_CAPACITY;
      end else if (item_i.is_pull) begin
        if (ph_q == ltd_pkg::PH_COPY && copy_q != 32'd0) begin
          rd_en = 1'b1;
          s2_d.has_byte = 1'b1;
          s2_d.from_mem = 1'b1;
          s2_d.fwd = s2v_q && s2_q.has_byte && (s2_q.wr_addr == rd_addr);
          prod_d = prod_q + 32'd1;
          copy_d = copy_q - 32'd1;
          if (copy_q == 32'd1) begin
            if (end_q) begin
              s2_d.done = 1'b1; s2_d.total = prod_q + 32'd1;
            end else begin
              ph_d = ltd_pkg::PH_TOKEN;
            end
          end
        end
      end else begin
        case (ph_q)
          ltd_pkg::PH_TOKEN: begin
            lit_d  = {28'd0, item_i.data[7:4]};
            base_d = item_i.data[3:0];
            len_chk = {28'd0, item_i.data[7:4]};
            if (item_i.data[7:4] == ltd_pkg::NIB_EXT) begin
              if (item_i.last) begin s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_TRUNC; end
              else ph_d = ltd_pkg::PH_LIT_EXT;
            end else begin
              cap_sum = {1'b0, prod_q} + {1'b0, len_chk};
              if (len_chk == 32'd0) begin
                if (item_i.last) begin s2_d.done = 1'b1; s2_d.total = prod_q; end
                else ph_d = ltd_pkg::PH_OFF_LO;
              end else if (item_i.last) begin
                s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_TRUNC;
              end else if (cap_sum > {1'b0, capacity_i}) begin
                s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_OVERFLOW;
              end else ph_d = ltd_pkg::PH_LITERALS;
            end
          end
          ltd_pkg::PH_LIT_EXT: begin
            ext_sum = {1'b0, lit_q} + {25'd0, item_i.data};
            len_chk = ext_sum[31:0];
            cap_sum = {1'b0, prod_q} + {1'b0, len_chk};
            if (ext_sum[32]) begin
              s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_OVERFLOW;
            end else begin
              lit_d = len_chk;
              if (item_i.data == ltd_pkg::BYTE_EXT) begin
                if (item_i.last) begin s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_TRUNC; end
              end else if (len_chk == 32'd0) begin
                if (item_i.last) begin s2_d.done = 1'b1; s2_d.total = prod_q; end
                else ph_d = ltd_pkg::PH_OFF_LO;
              end else if (item_i.last) begin
                s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_TRUNC;
              end else if (cap_sum > {1'b0, capacity_i}) begin
                s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_OVERFLOW;
              end else ph_d = ltd_pkg::PH_LITERALS;
            end
          end
          ltd_pkg::PH_LITERALS: begin
            if (item_i.last && lit_q > 32'd1) begin
              s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_TRUNC;
            end else begin
              s2_d.has_byte = 1'b1;
              prod_d = prod_q + 32'd1;
              lit_d  = lit_q - 32'd1;
              if (lit_q == 32'd1) begin
                if (item_i.last) begin s2_d.done = 1'b1; s2_d.total = prod_q + 32'd1; end
                else ph_d = ltd_pkg::PH_OFF_LO;
              end
            end
          end
          ltd_pkg::PH_OFF_LO: begin
            if (item_i.last) begin s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_TRUNC; end
            else begin
              off_d = {8'd0, item_i.data};
              ph_d  = ltd_pkg::PH_OFF_HI;
            end
          end
          ltd_pkg::PH_OFF_HI: begin
            off_d  = off_full;
            len_chk = 32'(base_q) + 32'(MinMatch);
            copy_d = len_chk;
            cap_sum = {1'b0, prod_q} + {1'b0, len_chk};
            if (off_full == 16'd0) begin
              s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_ZERO_OFF;
            end else if (base_q == ltd_pkg::NIB_EXT) begin
              if (item_i.last) begin s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_TRUNC; end
              else ph_d = ltd_pkg::PH_MATCH_EXT;
            end else if (prod_q < {16'd0, off_full}) begin
              s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_BEFORE;
            end else if (cap_sum > {1'b0, capacity_i}) begin
              s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_OVERFLOW;
            end else begin
              ph_d = ltd_pkg::PH_COPY; end_d = item_i.last;
            end
          end
          ltd_pkg::PH_MATCH_EXT: begin
            ext_sum = {1'b0, copy_q} + {25'd0, item_i.data};
            len_chk = ext_sum[31:0];
            cap_sum = {1'b0, prod_q} + {1'b0, len_chk};
            if (ext_sum[32]) begin
              s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_OVERFLOW;
            end else begin
              copy_d = len_chk;
              if (item_i.data == ltd_pkg::BYTE_EXT) begin
                if (item_i.last) begin s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_TRUNC; end
              end else if (prod_q < {16'd0, off_q}) begin
                s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_BEFORE;
              end else if (cap_sum > {1'b0, capacity_i}) begin
                s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_OVERFLOW;
              end else begin
                ph_d = ltd_pkg::PH_COPY; end_d = item_i.last;
              end
            end
          end
          default: begin
            s2_d.err = 1'b1; s2_d.code = ltd_pkg::ERR_BUSY;
          end
        endcase
      end
      if (s2_d.err) begin
        errl_d = 1'b1; code_d = s2_d.code;
      end
      // Done starts a new stream; the window is kept.
      if (s2_d.done) begin
        ph_d = ltd_pkg::PH_TOKEN; lit_d = '0; base_d = '0; off_d = '0;
        copy_d = '0; prod_d = '0; end_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= ltd_pkg::PH_TOKEN;
      lit_q <= '0; copy_q <= '0; prod_q <= '0; base_q <= '0; off_q <= '0;
      end_q <= 1'b0; errl_q <= 1'b0; code_q <= ltd_pkg::ERR_NONE;
      s2v_q <= 1'b0;
    end else begin
      ph_q <= ph_d; lit_q <= lit_d; copy_q <= copy_d; prod_q <= prod_d;
      base_q <= base_d; off_q <= off_d; end_q <= end_d;
      errl_q <= errl_d; code_q <= code_d;
      s2v_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q <= s2_d;
  end

  // Stage two: byte is from the literal, the window, or the byte just written.
  assign cur_byte = !s2_q.from_mem ? s2_q.lit : (s2_q.fwd ? last_byte_q : rdata_q);

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= win_q[rd_addr];
    if (s2v_q && s2_q.has_byte) begin
      win_q[s2_q.wr_addr] <= cur_byte;
      last_byte_q <= cur_byte;
    end
  end

  always_comb begin
    res0_o = '0;
    res1_o = '0;
    push0_o = s2v_q && (s2_q.err || s2_q.has_byte || s2_q.done);
    push1_o = s2v_q && s2_q.has_byte && s2_q.done;
    if (s2_q.err) begin
      res0_o.kind = ltd_pkg::KIND_ERROR; res0_o.code = s2_q.code;
    end else if (s2_q.has_byte) begin
      res0_o.kind = ltd_pkg::KIND_DATA; res0_o.out_byte = cur_byte;
    end else begin
      res0_o.kind = ltd_pkg::KIND_DONE; res0_o.total = s2_q.total;
    end
    res1_o.kind  = ltd_pkg::KIND_DONE;
    res1_o.total = s2_q.total;
  end

endmodule

// File: sv/lz77_token_stream_decoder_core.sv
// Top level of the LZ77 token stream decoder.
// Depends on ltd_pkg, ltd_in_fifo, ltd_engine, ltd_res_queue and the defines header.
//
// Usage:
//   Slave stream: tuser = opcode (0 feed one compressed byte, 1 pull one match byte),
//   tdata = compressed byte, tlast = final byte of the stream.
//   Master stream: tuser = kind (0 data, 1 done, 2 error), tdata packs out_byte,
//   total_length and error_code. Config channel writes capacity (index 0) and
//   expected size (index 1); other indexes are ignored. Write it only while idle.
// Throughput: one item per cycle while the result queue has room. The window RAM (one read, one write port) sets it:
//   a pull reads in the parse cycle and the byte is written back in stage two,
//   with a bypass so an offset of one still streams back to back.
// Path: an item passes the input queue and the parse stage register; the window
//   stage then writes its results straight into the result queue, which drives the
//   master port.
// Reset: clears parse state, sticky error and registers; the window RAM is not cleared
//   and needs no clearing pass, since a match only reads bytes of the current stream.
// Stall: a stalled receiver fills the 8-entry result queue; the engine holds once
//   fewer than two free slots remain beyond what is in flight, and the slave tready
//   drops when the two-entry input queue is full.
`include "lz77_token_stream_decoder_core_defines.svh"

module lz77_token_stream_decoder_core #(
  parameter int unsigned MinMatch = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] opcode
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] out_byte, [39:8] total_length,
                                      // [42:40] error_code, [47:43] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] capacity_q, expected_q;
  logic        q_valid, q_ready;
  ltd_pkg::item_t q_item;
  logic [ltd_pkg::ResCntW-1:0] level;
  logic        push0, push1;
  ltd_pkg::result_t res0, res1, out_res;

  // Configuration: always ready, one write per cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= '0;
      expected_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ltd_pkg::CFG_CAPACITY) capacity_q <= cfg_data_i;
      if (cfg_index_i == ltd_pkg::CFG_EXPECTED) expected_q <= cfg_data_i;
    end
  end

  // Front: accept and classify.
  ltd_in_fifo u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .opcode_i   (s_axis_tuser),
    .data_i     (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .out_valid_o(q_valid),
    .out_ready_i(q_ready),
    .out_item_o (q_item)
  );

  // Back: parse and copy.
  ltd_engine #(.MinMatch(MinMatch)) u_engine (
    .clk_i, .rst_ni,
    .in_valid_i (q_valid),
    .in_ready_o (q_ready),
    .item_i     (q_item),
    .capacity_i (capacity_q),
    .expected_i (expected_q),
    .level_i    (level),
    .push0_o    (push0),
    .res0_o     (res0),
    .push1_o    (push1),
    .res1_o     (res1)
  );

  ltd_res_queue u_results (
    .clk_i, .rst_ni,
    .push0_i    (push0),
    .res0_i     (res0),
    .push1_i    (push1),
    .res1_i     (res1),
    .level_o    (level),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_res_o  (out_res)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {5'd0, out_res.code, out_res.total, out_res.out_byte};

  `LTD_ASSERT_NOW(a_no_res_overflow, 1'b1, level <= 4'(ltd_pkg::ResDepth), "result queue overflow")
  `LTD_ASSERT_NOW(a_pair_order, push1, push0 && res0.kind == ltd_pkg::KIND_DATA, "done without byte")
  `LTD_ASSERT_NEXT(a_err_sticky, push0 && res0.kind == ltd_pkg::KIND_ERROR && !push1,
                   !push0 || res0.kind == ltd_pkg::KIND_ERROR, "error not sticky")

endmodule
